### rtl/cdr_pkg.sv
// shared types and constants for the streaming convolution block
`timescale 1ns / 1ps
`default_nettype none

package cdr_pkg;

    // configuration register geometry
    localparam int WROW_W    = 40;
    localparam int NUM_WROWS = 5;
    localparam int BIAS_W    = 32;
    localparam int DIM_W     = 7;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_ROW0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_ROW1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_ROW2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_ROW3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_ROW4 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_VALUE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_DIM   = 3'd6;

    localparam logic [DIM_W-1:0] IMAGE_DIM_RESET = 7'd28;

    // arithmetic widths, sized for kernels up to 5x5
    localparam int PROD_W = 17;
    localparam int CSUM_W = 20;
    localparam int ACC_W  = 34;

    // result queue
    localparam int FIFO_AW    = 3;
    localparam int FIFO_DEPTH = 2 ** FIFO_AW;

    localparam logic [7:0] OUT_MAX = 8'd255;

    typedef logic [7:0]               pix_t;
    typedef logic signed [7:0]        wgt_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [CSUM_W-1:0] csum_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } res_t;

endpackage

`default_nettype wire

### rtl/cdr_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module cdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/cdr_cell.sv
// one window column: holds kernel-height pixels, multiplies by its weight column
`timescale 1ns / 1ps
`default_nettype none

module cdr_cell #(
    parameter int KERNEL_DIM = 3
) (
    input  wire logic         clk,
    input  wire logic         shift,
    input  cdr_pkg::pix_t     col_in  [KERNEL_DIM],
    input  cdr_pkg::wgt_t     wgt     [KERNEL_DIM],
    output cdr_pkg::pix_t     col_out [KERNEL_DIM],
    output cdr_pkg::csum_t    sum
);

    cdr_pkg::pix_t  col_reg  [KERNEL_DIM];
    cdr_pkg::prod_t prod_reg [KERNEL_DIM];
    cdr_pkg::prod_t prod_next [KERNEL_DIM];
    cdr_pkg::csum_t sum_reg;
    cdr_pkg::csum_t sum_next;

    // column moves one place along the row of cells on every pixel transfer
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            col_reg <= col_in;
        end
    end

    always_comb
    begin
        for (int k = 0; k < KERNEL_DIM; k++)
        begin
            prod_next[k] = cdr_pkg::PROD_W'($signed({1'b0, col_reg[k]}))
                           * cdr_pkg::PROD_W'(wgt[k]);
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int k = 0; k < KERNEL_DIM; k++)
        begin
            sum_next = sum_next + cdr_pkg::CSUM_W'(prod_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        sum_reg  <= sum_next;
    end

    assign col_out = col_reg;
    assign sum     = sum_reg;

endmodule

`default_nettype wire

### rtl/cdr_out_fifo.sv
// small result queue between the arithmetic pipeline and the output channel
`timescale 1ns / 1ps
`default_nettype none

module cdr_out_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  cdr_pkg::res_t      push_item,
    input  wire logic          stall,
    output logic               valid,
    output cdr_pkg::res_t      item
);

    cdr_pkg::res_t                  mem_reg [cdr_pkg::FIFO_DEPTH];
    logic [cdr_pkg::FIFO_AW-1:0]    wr_ptr_reg;
    logic [cdr_pkg::FIFO_AW-1:0]    rd_ptr_reg;
    logic [cdr_pkg::FIFO_AW:0]      cnt_reg;
    logic [cdr_pkg::FIFO_AW:0]      cnt_next;
    logic                           pop;

    assign valid = (cnt_reg != '0);
    assign pop   = valid & ~stall;
    assign item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    // upstream credit count keeps pushes from ever hitting a full queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

### rtl/conv2d_relu_descale.sv
// streaming kxk convolution with relu, divide by 256 and clamp to one byte
// a result passes input, column, product, column-sum and accumulator registers, then the queue
// throughput: one pixel per cycle while src_stall is low, set by the row of window cells shifting once per transfer
// up to 8 results may be outstanding; pixel input stalls while 8 are in flight or queued
// reset clears counters, pipeline tags and result queue, and loads register defaults
// line buffer rams are not cleared; only entries already written feed an emitted result
`timescale 1ns / 1ps
`default_nettype none

module conv2d_relu_descale #(
    parameter int KERNEL_DIM    = 3,
    parameter int MAX_IMAGE_DIM = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [cdr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [cdr_pkg::WROW_W-1:0]        cfg_data,
    input  wire logic                              src_valid,
    output logic                                   src_stall,
    input  wire logic [7:0]                        pixel,
    input  wire logic                              frame_start,
    output logic                                   res_valid,
    input  wire logic                              res_stall,
    output logic [7:0]                             out_value,
    output logic                                   last_of_image
);

    localparam int CW     = $clog2(MAX_IMAGE_DIM);
    localparam int DW     = $clog2(MAX_IMAGE_DIM + 1);
    localparam int SW     = $clog2(KERNEL_DIM);
    localparam int EW     = (DW > cdr_pkg::DIM_W) ? DW : cdr_pkg::DIM_W;
    localparam int STAGES = 5;

    typedef struct packed {
        logic emit;
        logic last;
    } tag_t;

    // configuration registers
    logic [cdr_pkg::WROW_W-1:0] weight_reg [cdr_pkg::NUM_WROWS];
    logic [cdr_pkg::BIAS_W-1:0] bias_reg;
    logic [cdr_pkg::DIM_W-1:0]  image_dim_reg;

    // position counters
    logic [CW-1:0] col_reg;
    logic [CW-1:0] row_reg;
    logic [SW-1:0] slot_reg;
    logic [CW-1:0] col_next;
    logic [CW-1:0] row_next;
    logic [SW-1:0] slot_next;
    logic [CW-1:0] col_cur;
    logic [CW-1:0] row_cur;
    logic [SW-1:0] slot_cur;
    logic [DW-1:0] col_x;
    logic [DW-1:0] row_x;
    logic [DW-1:0] col_inc;
    logic [DW-1:0] row_inc;
    logic [DW-1:0] dim_d;
    logic [EW-1:0] dim_ext;
    logic          accept;
    logic          win_emit;
    logic          win_last;

    // first stage after transfer
    logic          a_valid_reg;
    cdr_pkg::pix_t a_pixel_reg;
    logic [SW-1:0] a_slot_reg;
    tag_t          tag_pipe_reg [STAGES];

    cdr_pkg::pix_t  bank_rd   [KERNEL_DIM];
    cdr_pkg::pix_t  chain_col [KERNEL_DIM+1][KERNEL_DIM];
    cdr_pkg::wgt_t  cell_wgt  [KERNEL_DIM][KERNEL_DIM];
    cdr_pkg::csum_t cell_sum  [KERNEL_DIM];

    cdr_pkg::acc_t  acc_reg;
    cdr_pkg::acc_t  acc_next;
    cdr_pkg::res_t  res_item;
    cdr_pkg::res_t  head_item;

    logic [cdr_pkg::FIFO_AW:0] pend_reg;
    logic [cdr_pkg::FIFO_AW:0] pend_next;
    logic                      res_xfer;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < cdr_pkg::NUM_WROWS; i++)
            begin
                weight_reg[i] <= '0;
            end
            bias_reg      <= '0;
            image_dim_reg <= cdr_pkg::IMAGE_DIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cdr_pkg::CFG_WEIGHT_ROW0: weight_reg[0] <= cfg_data;
                cdr_pkg::CFG_WEIGHT_ROW1: weight_reg[1] <= cfg_data;
                cdr_pkg::CFG_WEIGHT_ROW2: weight_reg[2] <= cfg_data;
                cdr_pkg::CFG_WEIGHT_ROW3: weight_reg[3] <= cfg_data;
                cdr_pkg::CFG_WEIGHT_ROW4: weight_reg[4] <= cfg_data;
                cdr_pkg::CFG_BIAS_VALUE:  bias_reg <= cfg_data[cdr_pkg::BIAS_W-1:0];
                cdr_pkg::CFG_IMAGE_DIM:   image_dim_reg <= cfg_data[cdr_pkg::DIM_W-1:0];
                default:                  ;
            endcase
        end
    end

    // effective side length: oversize saturates, zero acts as one
    always_comb
    begin
        dim_ext = EW'(image_dim_reg);
        if (dim_ext > EW'(MAX_IMAGE_DIM))
        begin
            dim_d = DW'(MAX_IMAGE_DIM);
        end
        else if (image_dim_reg == '0)
        begin
            dim_d = DW'(1);
        end
        else
        begin
            dim_d = DW'(image_dim_reg);
        end
    end

    assign src_stall = (pend_reg == (cdr_pkg::FIFO_AW + 1)'(cdr_pkg::FIFO_DEPTH));
    assign accept    = src_valid & ~src_stall;

    assign col_cur  = frame_start ? '0 : col_reg;
    assign row_cur  = frame_start ? '0 : row_reg;
    assign slot_cur = frame_start ? '0 : slot_reg;
    assign col_x    = DW'(col_cur);
    assign row_x    = DW'(row_cur);
    assign col_inc  = col_x + DW'(1);
    assign row_inc  = row_x + DW'(1);

    assign win_emit = (dim_d >= DW'(KERNEL_DIM)) && (row_x < dim_d) && (col_x < dim_d)
                      && (row_x >= DW'(KERNEL_DIM - 1)) && (col_x >= DW'(KERNEL_DIM - 1));
    assign win_last = (row_x == dim_d - DW'(1)) && (col_x == dim_d - DW'(1));

    // slot tracks row modulo kernel height, i.e. which line buffer bank gets this row
    always_comb
    begin
        col_next  = CW'(col_inc);
        row_next  = row_cur;
        slot_next = slot_cur;
        if (col_inc >= dim_d)
        begin
            col_next = '0;
            if (row_inc >= dim_d)
            begin
                row_next  = '0;
                slot_next = '0;
            end
            else
            begin
                row_next  = CW'(row_inc);
                slot_next = (slot_cur == SW'(KERNEL_DIM - 1)) ? '0 : slot_cur + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            slot_reg    <= '0;
            a_valid_reg <= 1'b0;
            for (int s = 0; s < STAGES; s++)
            begin
                tag_pipe_reg[s] <= '0;
            end
        end
        else
        begin
            if (accept)
            begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                slot_reg <= slot_next;
            end
            a_valid_reg          <= accept;
            tag_pipe_reg[0].emit <= accept & win_emit;
            tag_pipe_reg[0].last <= win_last;
            for (int s = 1; s < STAGES; s++)
            begin
                tag_pipe_reg[s] <= tag_pipe_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_pixel_reg <= pixel;
            a_slot_reg  <= slot_cur;
        end
    end

    // line buffer banks, one per kernel row slot
    for (genvar b = 0; b < KERNEL_DIM; b++)
    begin : g_bank
        cdr_ram #(
            .WIDTH (8),
            .DEPTH (MAX_IMAGE_DIM)
        ) u_bank (
            .clk     (clk),
            .wr_en   (accept && (slot_cur == SW'(b))),
            .wr_addr (col_cur),
            .wr_data (pixel),
            .rd_en   (accept),
            .rd_addr (col_cur),
            .rd_data (bank_rd[b])
        );
    end

    // assemble the new window column, oldest row first, current pixel at the bottom
    always_comb
    begin
        int            idx;
        logic [SW-1:0] sel;
        for (int kr = 0; kr < KERNEL_DIM; kr++)
        begin
            idx = int'(a_slot_reg) + 1 + kr;
            if (idx >= KERNEL_DIM)
            begin
                idx = idx - KERNEL_DIM;
            end
            sel = SW'(idx);
            if (kr == KERNEL_DIM - 1)
            begin
                chain_col[KERNEL_DIM][kr] = a_pixel_reg;
            end
            else
            begin
                chain_col[KERNEL_DIM][kr] = bank_rd[sel];
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < KERNEL_DIM; j++)
        begin
            for (int kr = 0; kr < KERNEL_DIM; kr++)
            begin
                cell_wgt[j][kr] = weight_reg[kr][8*j +: 8];
            end
        end
    end

    // row of window cells; cell j holds window column j
    for (genvar j = 0; j < KERNEL_DIM; j++)
    begin : g_cell
        cdr_cell #(
            .KERNEL_DIM (KERNEL_DIM)
        ) u_cell (
            .clk     (clk),
            .shift   (a_valid_reg),
            .col_in  (chain_col[j+1]),
            .wgt     (cell_wgt[j]),
            .col_out (chain_col[j]),
            .sum     (cell_sum[j])
        );
    end

    always_comb
    begin
        acc_next = cdr_pkg::ACC_W'($signed(bias_reg));
        for (int j = 0; j < KERNEL_DIM; j++)
        begin
            acc_next = acc_next + cdr_pkg::ACC_W'(cell_sum[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // relu, divide by 256, clamp
    always_comb
    begin
        res_item.last = tag_pipe_reg[STAGES-1].last;
        if (acc_reg[cdr_pkg::ACC_W-1] || (acc_reg == '0))
        begin
            res_item.value = '0;
        end
        else if (|acc_reg[cdr_pkg::ACC_W-2:16])
        begin
            res_item.value = cdr_pkg::OUT_MAX;
        end
        else
        begin
            res_item.value = acc_reg[15:8];
        end
    end

    cdr_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (tag_pipe_reg[STAGES-1].emit),
        .push_item (res_item),
        .stall     (res_stall),
        .valid     (res_valid),
        .item      (head_item)
    );

    assign out_value     = head_item.value;
    assign last_of_image = head_item.last;

    // credits: windows accepted but not yet transferred out
    assign res_xfer = res_valid & ~res_stall;

    always_comb
    begin
        pend_next = pend_reg;
        if ((accept && win_emit) && !res_xfer)
        begin
            pend_next = pend_reg + 1'b1;
        end
        else if (!(accept && win_emit) && res_xfer)
        begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

endmodule

`default_nettype wire
